[rtl/core/mpfd_pkg.sv]
// Package for the monochrome page framebuffer: sizes, command codes and the item types.
`timescale 1ns / 1ps
`default_nettype none
package mpfd_pkg;

	// default screen geometry
	localparam int SCREEN_WIDTH_DEF    = 128;
	localparam int SCREEN_HEIGHT_DEF   = 64;
	localparam int GLYPH_MAX_WIDTH_DEF = 16;

	// command codes carried in the slave tuser
	typedef enum logic [2:0] {
		CMD_FILL  = 3'd0,
		CMD_PIXEL = 3'd1,
		CMD_RECT  = 3'd2,
		CMD_GLYPH = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	// bytes written by a fill
	localparam logic [7:0] BYTE_BLACK = 8'h00;
	localparam logic [7:0] BYTE_WHITE = 8'hFF;

	// stream widths, padded to whole bytes
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 16;

endpackage
`default_nettype wire

[rtl/core/mpfd_ram.sv]
// Generic single-address RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mpfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read first port: a write cycle returns the old word, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

[rtl/core/mono_page_framebuffer_draw.sv]
// Top level of the monochrome page framebuffer: command sequencer around one pixel RMW unit.
//
//  channel  dir  tdata                                   tuser
//  s_*      in   pos_x,pos_y,corner_x,corner_y,colour,   cmd[2:0]
//                glyph_bits,glyph_width (56 bits)
//  m_*      out  read_byte,status (16 bits)              -
//
// A pixel, rectangle or glyph walk reads and then modifies and writes each pixel
// through the single RAM port (read, then modify and write). Fill sweeps the
// store at 1 byte a cycle. A read passes through ST_RD and then ST_RD_DAT.
// After reset a clearing sweep of the whole store (1024 bytes at default size)
// runs before the first item is taken. s_tready is high only when idle; a finished
// reply waits in the output register while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
module mono_page_framebuffer_draw #(
	parameter int SCREEN_WIDTH    = mpfd_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT   = mpfd_pkg::SCREEN_HEIGHT_DEF,
	parameter int GLYPH_MAX_WIDTH = mpfd_pkg::GLYPH_MAX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// pos_x[7:0] pos_y[15:8] corner_x[23:16] corner_y[31:24] colour[32]
	// glyph_bits[48:33] glyph_width[53:49] zero[55:54]
	input  wire logic [mpfd_pkg::IN_DATA_W-1:0]   s_tdata,
	// cmd[2:0]
	input  wire logic [2:0]                       s_tuser,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// read_byte[7:0] status[8] zero[15:9]
	output logic      [mpfd_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import mpfd_pkg::*;

	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int DEPTH = SCREEN_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_PIX_RD = 7'b0000100,
		ST_PIX_WR = 7'b0001000,
		ST_RD     = 7'b0010000,
		ST_RD_DAT = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   sweep_q;
	logic [7:0]      fill_q;
	logic            fill_reply_q;
	logic [7:0]      x_q, y_q, x0_q, x1_q, y1_q;
	logic [15:0]     bits_q;
	logic [4:0]      cnt_q;
	logic            glyph_q;
	logic            rect_q;
	logic            col_q;
	logic [7:0]      rbyte_q;
	logic            rst_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_st_q;

	// input fields
	logic [7:0]  pos_x, pos_y, corner_x, corner_y;
	logic        colour;
	logic [15:0] glyph_bits;
	logic [4:0]  glyph_width;
	assign pos_x       = s_tdata[7:0];
	assign pos_y       = s_tdata[15:8];
	assign corner_x    = s_tdata[23:16];
	assign corner_y    = s_tdata[31:24];
	assign colour      = s_tdata[32];
	assign glyph_bits  = s_tdata[48:33];
	assign glyph_width = s_tdata[53:49];

	// rectangle corner ordering and clipping
	logic [7:0] rx0, rx1, ry0, ry1;
	always_comb begin
		rx0 = (pos_x <= corner_x) ? pos_x : corner_x;
		rx1 = (pos_x <= corner_x) ? corner_x : pos_x;
		ry0 = (pos_y <= corner_y) ? pos_y : corner_y;
		ry1 = (pos_y <= corner_y) ? corner_y : pos_y;
		if (9'(rx1) > 9'(SCREEN_WIDTH - 1)) rx1 = 8'(SCREEN_WIDTH - 1);
		if (9'(ry1) > 9'(SCREEN_HEIGHT - 1)) ry1 = 8'(SCREEN_HEIGHT - 1);
	end

	// glyph and range checks
	logic glyph_bad, pix_off, read_bad;
	assign glyph_bad = (6'(glyph_width) > 6'(GLYPH_MAX_WIDTH))
		|| ((9'(pos_x) + 9'(glyph_width)) > 9'(SCREEN_WIDTH));
	assign pix_off   = (9'(pos_x) >= 9'(SCREEN_WIDTH)) || (9'(pos_y) >= 9'(SCREEN_HEIGHT));
	assign read_bad  = (9'(pos_x) >= 9'(SCREEN_WIDTH)) || (9'(pos_y) >= 9'(PAGES));

	// byte address of the current pixel
	logic [AW-1:0] pix_addr;
	assign pix_addr = AW'(32'(y_q[7:3]) * SCREEN_WIDTH + 32'(x_q));

	// pixel modify
	logic       draw_white;
	logic [7:0] mask;
	logic [7:0] rdata;
	logic [7:0] wbyte;
	assign draw_white = glyph_q ? (bits_q[15] ? col_q : !col_q) : col_q;
	assign mask       = 8'(1) << y_q[2:0];
	assign wbyte      = draw_white ? (rdata | mask) : (rdata & ~mask);

	// end of walk
	logic last_pix;
	always_comb begin
		if (glyph_q) begin
			last_pix = (cnt_q == 5'd1);
		end else if (rect_q) begin
			last_pix = (x_q == x1_q) && (y_q == y1_q);
		end else begin
			last_pix = 1'b1;
		end
	end

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = pix_addr;
		ram_wdata = wbyte;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_addr  = sweep_q;
			ram_wdata = fill_q;
		end else if (state_q == ST_PIX_WR) begin
			ram_we = 1'b1;
		end
	end

	mpfd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_st_q, out_byte_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sweep_q      <= '0;
			fill_q       <= BYTE_BLACK;
			fill_reply_q <= 1'b0;
			glyph_q      <= 1'b0;
			rect_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			rst_q        <= 1'b0;
		end else begin
			// output register: load a finished reply, or drop one that was taken
			if (state_q == ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (32'(sweep_q) == DEPTH - 1) begin
						sweep_q <= '0;
						rbyte_q <= BYTE_BLACK;
						rst_q   <= 1'b0;
						state_q <= fill_reply_q ? ST_DONE : ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						col_q   <= colour;
						rbyte_q <= BYTE_BLACK;
						rst_q   <= 1'b0;
						glyph_q <= 1'b0;
						rect_q  <= 1'b0;
						case (s_tuser)
							CMD_FILL: begin
								fill_q       <= colour ? BYTE_WHITE : BYTE_BLACK;
								fill_reply_q <= 1'b1;
								state_q      <= ST_CLEAR;
							end
							CMD_PIXEL: begin
								x_q     <= pos_x;
								y_q     <= pos_y;
								state_q <= pix_off ? ST_DONE : ST_PIX_RD;
							end
							CMD_RECT: begin
								x_q     <= rx0;
								x0_q    <= rx0;
								x1_q    <= rx1;
								y_q     <= ry0;
								y1_q    <= ry1;
								rect_q  <= 1'b1;
								state_q <= (rx0 <= rx1 && ry0 <= ry1) ? ST_PIX_RD : ST_DONE;
							end
							CMD_GLYPH: begin
								x_q     <= pos_x;
								y_q     <= pos_y;
								bits_q  <= glyph_bits;
								cnt_q   <= glyph_width;
								glyph_q <= 1'b1;
								if (glyph_bad) begin
									rst_q   <= 1'b1;
									state_q <= ST_DONE;
								end else if (glyph_width != 5'd0
									&& 9'(pos_y) < 9'(SCREEN_HEIGHT)) begin
									state_q <= ST_PIX_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							CMD_READ: begin
								x_q <= pos_x;
								y_q <= {pos_y[4:0], 3'b000};
								if (read_bad) begin
									rst_q   <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_RD;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PIX_RD: state_q <= ST_PIX_WR;
				ST_PIX_WR: begin
					if (last_pix) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_PIX_RD;
						bits_q  <= {bits_q[14:0], 1'b0};
						cnt_q   <= cnt_q - 5'd1;
						if (rect_q && x_q == x1_q) begin
							x_q <= x0_q;
							y_q <= y_q + 8'd1;
						end else begin
							x_q <= x_q + 8'd1;
						end
					end
				end
				ST_RD: state_q <= ST_RD_DAT;
				ST_RD_DAT: begin
					rbyte_q <= rdata;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_byte_q   <= rbyte_q;
						out_st_q     <= rst_q;
						fill_reply_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// store is written only by the sweep or the pixel unit
	a_we_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_PIX_WR))
		else $error("store written outside sweep or pixel write");

	// a write always follows its read
	a_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX_WR) |-> $past(state_q) == ST_PIX_RD)
		else $error("pixel write without read");

	// a new reply never overwrites one still waiting
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_byte_q)))
		else $error("pending reply lost");

	// walks stay within the screen columns
	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX_WR) |-> (9'(x_q) < 9'(SCREEN_WIDTH)))
		else $error("pixel column off screen");

endmodule
`default_nettype wire
